// ----- sv/event_row_window_filter_defines.svh -----
// Assertion macros shared by the event row window filter RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef EVENT_ROW_WINDOW_FILTER_DEFINES_SVH
`define EVENT_ROW_WINDOW_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERWF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERWF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/erwf_pkg.sv -----
// Shared types and constants of the event row window filter.
// No dependencies; the front end, job queue, emitter and top level use it.
`default_nettype none

package erwf_pkg;

	localparam int ROW_W  = 10;
	localparam int COL_W  = 11;
	localparam int DIST_W = 11;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register index as decoded from paddr[2].
	localparam logic REG_MAX_DISTANCE = 1'b0;
	localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 11'd6;

	typedef struct packed {
		logic             packet_start;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_column;
		logic             last_of_burst;
	} out_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ----- sv/erwf_front.sv -----
// Front end: tracks the row run and column history and classifies each event.
// Depends on erwf_pkg; pushes one emission job per passing window.
`default_nettype none

module erwf_front #(
	parameter int WINDOW = 4
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire logic [erwf_pkg::DIST_W-1:0]                 max_distance,
	input  wire erwf_pkg::in_item_t                          item,
	input  wire                                              accept,
	output logic                                             job_push,
	output logic [erwf_pkg::ROW_W+WINDOW*erwf_pkg::COL_W:0]  job
);

	localparam int CNT_W = $clog2(WINDOW);
	localparam int CW    = erwf_pkg::COL_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW - 1);

	logic [erwf_pkg::ROW_W-1:0] cur_row_q;
	logic [CNT_W-1:0]           run_count_q;
	logic                       chain_q;
	logic [CW-1:0]              hist_q [WINDOW-1];

	logic                   new_run;
	logic [CNT_W-1:0]       eff_count;
	logic                   eff_chain;
	logic                   full_win;
	logic [CW:0]            diff;
	logic                   pass;
	logic [WINDOW*CW-1:0]   cols;

	always_comb begin
		new_run   = item.packet_start || (item.row != cur_row_q);
		eff_count = new_run ? '0 : run_count_q;
		eff_chain = new_run ? 1'b0 : chain_q;
		full_win  = (eff_count == FULL_CNT);
		diff      = {1'b0, item.column} - {1'b0, hist_q[0]};
		pass      = $signed(diff) < $signed({1'b0, max_distance});
		for (int i = 0; i < WINDOW - 1; i++) begin
			cols[i*CW +: CW] = hist_q[i];
		end
		cols[(WINDOW-1)*CW +: CW] = item.column;
		job_push = accept && full_win && pass;
		job      = {item.row, !eff_chain, cols};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			run_count_q <= '0;
			chain_q     <= 1'b0;
		end else if (accept) begin
			cur_row_q <= item.row;
			if (full_win) begin
				run_count_q <= eff_count;
				chain_q     <= pass;
			end else begin
				run_count_q <= eff_count + 1'b1;
				chain_q     <= eff_chain;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				if (full_win) begin
					hist_q[i] <= (i == WINDOW - 2) ? item.column : hist_q[i+1];
				end else if (eff_count == CNT_W'(i)) begin
					hist_q[i] <= item.column;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/erwf_job_queue.sv -----
// Two-entry job queue between the front end and the emitter.
// Depends on erwf_pkg for the status struct.
`default_nettype none

module erwf_job_queue #(
	parameter int DATA_W = 56
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       wr_en,
	input  wire logic [DATA_W-1:0]    wr_data,
	input  wire                       rd_en,
	output logic [DATA_W-1:0]         rd_data,
	output erwf_pkg::q_status_t       status
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	always_comb begin
		status.full  = (count_q == 2'd2);
		status.empty = (count_q == 2'd0);
		rd_data      = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- sv/erwf_back.sv -----
// Emitter: takes one job from the queue and sends its events out one per pop.
// Depends on erwf_pkg; a job that opens a chain yields WINDOW results, a chained job only its newest column.
`default_nettype none

module erwf_back #(
	parameter int WINDOW = 4
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire erwf_pkg::q_status_t                         qstat,
	input  wire logic [erwf_pkg::ROW_W+WINDOW*erwf_pkg::COL_W:0] job,
	output logic                                             job_pop,
	output logic                                             empty,
	input  wire                                              pop,
	output erwf_pkg::out_item_t                              result
);

	localparam int CNT_W = $clog2(WINDOW);
	localparam int CW    = erwf_pkg::COL_W;
	localparam int JOB_W = erwf_pkg::ROW_W + WINDOW * CW + 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW - 1);

	logic [JOB_W-1:0] job_q;
	logic             busy_q;
	logic [CNT_W-1:0] idx_q;
	logic             done;
	logic             burst_in;

	always_comb begin
		done     = busy_q && pop && (idx_q == LAST);
		job_pop  = !qstat.empty && (!busy_q || done);
		burst_in = job[WINDOW*CW];
		empty    = !busy_q;
		result.out_row       = job_q[JOB_W-1 -: erwf_pkg::ROW_W];
		result.out_column    = job_q[idx_q*CW +: CW];
		result.last_of_burst = (idx_q == LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			idx_q  <= burst_in ? '0 : LAST;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && pop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
	end

endmodule

`default_nettype wire

// ----- sv/event_row_window_filter.sv -----
// Top level of the event row window filter: config register, front end, job queue, emitter.
// Depends on erwf_pkg, erwf_front, erwf_job_queue, erwf_back and the assertion macro header.
`default_nettype none

// The filter accepts one event per clock while full is low. A passing window becomes a
// job in a two-entry queue; the emitter drains it at one result per pop, so the first
// window of a chain yields WINDOW results and each later passing window one. full rises
// only when both queue entries wait behind an emitting burst. A job is registered in a
// queue entry and then in the emitter's job register before its first result appears.
// max_distance resets to 6 and is written through the APB port at byte addresses 0 to 3.
`include "event_row_window_filter_defines.svh"

module event_row_window_filter #(
	parameter int WINDOW = 4
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire logic [erwf_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [erwf_pkg::DATA_W-1:0]    pwdata,
	output logic [erwf_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  wire                                 push,
	output logic                                full,
	input  wire erwf_pkg::in_item_t             item,
	output logic                                empty,
	input  wire                                 pop,
	output erwf_pkg::out_item_t                 result
);

	localparam int JOB_W = erwf_pkg::ROW_W + WINDOW * erwf_pkg::COL_W + 1;

	logic [erwf_pkg::DIST_W-1:0] max_distance_q;
	logic                        cfg_wr;
	logic                        accept;
	logic                        job_push;
	logic                        job_pop;
	logic [JOB_W-1:0]            job_in;
	logic [JOB_W-1:0]            job_out;
	erwf_pkg::q_status_t         qstat;

	always_comb begin
		pready = 1'b1;
		cfg_wr = psel && penable && pwrite && (paddr[2] == erwf_pkg::REG_MAX_DISTANCE);
		prdata = (paddr[2] == erwf_pkg::REG_MAX_DISTANCE) ?
			{{(erwf_pkg::DATA_W - erwf_pkg::DIST_W){1'b0}}, max_distance_q} : '0;
		full   = qstat.full;
		accept = push && !qstat.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= erwf_pkg::MAX_DISTANCE_RESET;
		end else if (cfg_wr) begin
			max_distance_q <= pwdata[erwf_pkg::DIST_W-1:0];
		end
	end

	erwf_front #(.WINDOW(WINDOW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_distance (max_distance_q),
		.item         (item),
		.accept       (accept),
		.job_push     (job_push),
		.job          (job_in)
	);

	erwf_job_queue #(.DATA_W(JOB_W)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.status  (qstat)
	);

	erwf_back #(.WINDOW(WINDOW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.job     (job_out),
		.job_pop (job_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	`ERWF_ASSERT_SAME(a_queue_status, qstat.full, !qstat.empty, "Job queue is full and empty at once.")
	`ERWF_ASSERT_NEXT(a_burst_continues, !empty && pop && !result.last_of_burst, !empty, "Burst ended without its last result.")
	`ERWF_ASSERT_NEXT(a_cfg_write, cfg_wr, max_distance_q == $past(pwdata[erwf_pkg::DIST_W-1:0]), "max_distance write was lost.")
	`ERWF_ASSERT_SAME(a_no_push_when_full, job_push, !qstat.full, "Job pushed into a full queue.")

endmodule

`default_nettype wire
